FILE: rtl/chd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

  localparam int LEN_W = 21;

  localparam logic [LEN_W-1:0] MAX_BODY_RESET = LEN_W'(1024 * 1024);

  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  // status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_BADHEX  = 3'd2;
  localparam logic [2:0] ST_TOOBIG  = 3'd3;
  localparam logic [2:0] ST_BADLINE = 3'd4;
  localparam logic [2:0] ST_SHORT   = 3'd5;
  localparam logic [2:0] ST_NOCRLF  = 3'd6;
  localparam logic [2:0] ST_EARLY   = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic             data_valid;
    logic [7:0]       out_byte;
    logic [2:0]       status;
    logic [LEN_W-1:0] body_length;
  } result_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/chd_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// Input pipeline register: holds one accepted transaction until the engine takes it.
module chd_in_reg
  import chd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_data,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  take
);

  logic  hold_valid;
  item_t hold;

  assign in_ready   = !hold_valid || take;
  assign item_valid = hold_valid;
  assign item       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/chd_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Decoder state, one-byte step logic and the result register.
module chd_engine
  import chd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [LEN_W-1:0] max_body,
  input  wire logic             item_valid,
  input  wire item_t            item,
  output logic                  take,
  output logic                  res_valid,
  output result_t               res,
  input  wire logic             out_ready
);

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SIZE,
    PH_EXT,
    PH_SIZE_LF,
    PH_DATA,
    PH_DATA_CR,
    PH_DATA_LF
  } phase_t;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] chunk_remaining, chunk_remaining_next;
  logic [LEN_W-1:0] decoded_total, decoded_total_next;
  logic             saw_hex_digit, saw_hex_digit_next;
  logic [2:0]       status, status_next;
  logic             dv_next;

  logic [4:0]       hex;
  logic [LEN_W+3:0] size_shift;
  logic [LEN_W:0]   total_sum;

  assign take       = item_valid && (!res_valid || out_ready);
  assign hex        = hex_value(item.in_byte);
  assign size_shift = {chunk_remaining, hex[3:0]};
  assign total_sum  = {1'b0, decoded_total} + {1'b0, chunk_remaining};

  always_comb begin
    phase_t ph;
    ph                   = phase;
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    decoded_total_next   = decoded_total;
    saw_hex_digit_next   = saw_hex_digit;
    status_next          = status;
    dv_next              = 1'b0;
    if (status == ST_RUN) begin
      if (phase == PH_LINE_START) begin
        ph = PH_SIZE;
      end
      phase_next = ph;
      case (ph)
        PH_SIZE: begin
          if (item.in_byte == CHAR_CR) begin
            if (saw_hex_digit) phase_next = PH_SIZE_LF;
            else status_next = ST_BADLINE;
          end else if (item.in_byte == CHAR_LF) begin
            status_next = ST_BADLINE;
          end else if (item.in_byte == CHAR_SEMI) begin
            phase_next = PH_EXT;
          end else if (!hex[4]) begin
            status_next = ST_BADHEX;
          end else begin
            saw_hex_digit_next = 1'b1;
            if (size_shift > {4'd0, max_body}) status_next = ST_TOOBIG;
            else chunk_remaining_next = size_shift[LEN_W-1:0];
          end
        end
        PH_EXT: begin
          if (item.in_byte == CHAR_CR) begin
            if (saw_hex_digit) phase_next = PH_SIZE_LF;
            else status_next = ST_BADLINE;
          end
        end
        PH_SIZE_LF: begin
          if (item.in_byte != CHAR_LF) begin
            status_next = ST_BADLINE;
          end else if (chunk_remaining == '0) begin
            status_next = ST_DONE;
          end else if (total_sum > {1'b0, max_body}) begin
            status_next = ST_SHORT;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          dv_next              = 1'b1;
          decoded_total_next   = decoded_total + LEN_W'(1);
          chunk_remaining_next = chunk_remaining - LEN_W'(1);
          if (chunk_remaining == LEN_W'(1)) phase_next = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (item.in_byte == CHAR_CR) phase_next = PH_DATA_LF;
          else status_next = ST_NOCRLF;
        end
        PH_DATA_LF: begin
          if (item.in_byte == CHAR_LF) begin
            phase_next           = PH_LINE_START;
            chunk_remaining_next = '0;
            saw_hex_digit_next   = 1'b0;
          end else begin
            status_next = ST_NOCRLF;
          end
        end
        default: begin
          status_next = ST_BADLINE;
        end
      endcase

      if (item.last_byte && status_next == ST_RUN) begin
        case (phase_next)
          PH_LINE_START:         status_next = ST_EARLY;
          PH_DATA:               status_next = ST_SHORT;
          PH_DATA_CR, PH_DATA_LF: status_next = ST_NOCRLF;
          default:               status_next = ST_BADLINE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LINE_START;
      chunk_remaining <= '0;
      decoded_total   <= '0;
      saw_hex_digit   <= 1'b0;
      status          <= ST_RUN;
      res_valid       <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      decoded_total   <= decoded_total_next;
      saw_hex_digit   <= saw_hex_digit_next;
      status          <= status_next;
      res_valid       <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.data_valid  <= dv_next;
      res.out_byte    <= dv_next ? item.in_byte : 8'd0;
      res.status      <= status_next;
      res.body_length <= decoded_total_next;
    end
  end

  // a payload byte may carry the end-of-input code when it is the final byte
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.data_valid
    |-> res.status == ST_RUN || res.status == ST_SHORT || res.status == ST_NOCRLF)
    else $error("payload byte reported with an unexpected status");

  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    status != ST_RUN |=> $stable(status))
    else $error("terminal status changed");

  a_data_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_remaining != '0)
    else $error("data phase with no bytes remaining");

  a_total_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && decoded_total != $past(decoded_total)
    |-> decoded_total == LEN_W'($past(decoded_total) + LEN_W'(1)))
    else $error("decoded total moved by more than one byte");

endmodule

`default_nettype wire

FILE: rtl/http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | direction | handshake           | payload
// --------+-----------+---------------------+------------------------------------
// in      | input     | in_valid/in_ready   | item_t: in_byte, last_byte
// out     | output    | out_valid/out_ready | result_t: data_valid, out_byte,
//         |           |                     |   status, body_length
// cfg     | input     | cfg_valid/cfg_ready | max_body (21 bits), always ready
//
// One result transaction for every input transaction, one byte per clock while out
// does not stall. Path: input register, then the step logic into the result register.
// The decoder state lives beside the result register and updates once per byte,
// so a byte can follow the previous one in the next cycle.
// Reset (rst, synchronous) returns to the start of a size line, zero totals,
// status running, and max_body to 1 MiB.
// A stall on out holds the result and fills the input register; in_ready drops
// only when both are full.
module http_chunked_body_decoder_top
  import chd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire item_t            in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] max_body;
  logic             item_valid;
  item_t            item;
  logic             take;

  // The user must land writes only while idle; unenforced, the register is always open.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body <= MAX_BODY_RESET;
    end else if (cfg_valid) begin
      max_body <= cfg_data;
    end
  end

  chd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // Per-byte parse: size line, extension skip, data pass-through, CRLF checks,
  // limit checks against max_body and sticky status.
  chd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .max_body   (max_body),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (out_valid),
    .res        (out_data),
    .out_ready  (out_ready)
  );

endmodule

`default_nettype wire

FILE: sim/tb_http_chunked_body_decoder_top.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder_top;
  import chd_pkg::*;

  // Overall run bound in clock cycles; a correct run needs far fewer.
  localparam int CYCLE_LIMIT = 400000;
  // Input transactions that must reach the decoder while it is still running.
  localparam int LIVE_TARGET = 880;

  // Where the decoder is inside the chunked framing.
  typedef enum logic [2:0] {
    P_LINE_START,
    P_SIZE,
    P_EXT,
    P_SIZE_LF,
    P_DATA,
    P_DATA_CR,
    P_DATA_LF
  } parse_phase_t;

  // One row of the directed table: a register write or a byte, optionally with
  // the result typed in by hand.
  typedef struct packed {
    logic             is_cfg;
    logic [LEN_W-1:0] cfg_val;
    item_t            stim;
    logic             typed;
    result_t          want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  item_t            in_data;
  logic             out_valid;
  logic             out_ready;
  result_t          out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  // Shadow of the decoder: framing state, running totals and the register.
  parse_phase_t     parse_ph     = P_LINE_START;
  logic [LEN_W-1:0] size_left    = '0;
  logic [LEN_W-1:0] total_out    = '0;
  logic             digit_seen   = 1'b0;
  logic [2:0]       body_status  = ST_RUN;
  logic [LEN_W-1:0] max_body_lim = MAX_BODY_RESET;

  result_t   pending_results[$];
  plan_row_t plan[$];
  result_t   oldest;
  int        mismatch_count = 0;
  int        results_seen   = 0;
  int        cycle_count    = 0;
  int        live_items     = 0;
  logic      calm_in        = 1'b0;
  logic      calm_out       = 1'b0;

  http_chunked_body_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -1 for anything that is not a hex digit
  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    return -1;
  endfunction

  // Nibble to ASCII, letters in a random case.
  function automatic logic [7:0] ascii_hex(logic [3:0] d);
    if (d < 4'd10) return 8'h30 + 8'(d);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] any_byte_but(logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == avoid) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Advance the shadow decoder by one byte and return the result it must give.
  function automatic result_t decode_step(logic [7:0] b, logic last);
    result_t     r;
    int          nib;
    logic [24:0] grown;
    r = '0;
    if (body_status == ST_RUN) begin
      if (parse_ph == P_LINE_START) parse_ph = P_SIZE;
      case (parse_ph)
        P_SIZE: begin
          nib = hex_digit(b);
          if (b == CHAR_CR) begin
            if (digit_seen) parse_ph = P_SIZE_LF;
            else body_status = ST_BADLINE;
          end else if (b == CHAR_LF) begin
            body_status = ST_BADLINE;
          end else if (b == CHAR_SEMI) begin
            parse_ph = P_EXT;
          end else if (nib < 0) begin
            body_status = ST_BADHEX;
          end else begin
            grown = {size_left, 4'(nib)};
            digit_seen = 1'b1;
            if (grown > 25'(max_body_lim)) body_status = ST_TOOBIG;
            else size_left = grown[LEN_W-1:0];
          end
        end
        P_EXT: begin
          // everything up to CR is skipped, a stray LF too
          if (b == CHAR_CR) begin
            if (digit_seen) parse_ph = P_SIZE_LF;
            else body_status = ST_BADLINE;
          end
        end
        P_SIZE_LF: begin
          if (b != CHAR_LF) body_status = ST_BADLINE;
          else if (size_left == '0) body_status = ST_DONE;
          else if ({1'b0, total_out} + {1'b0, size_left} > {1'b0, max_body_lim})
            body_status = ST_SHORT;
          else parse_ph = P_DATA;
        end
        P_DATA: begin
          r.data_valid = 1'b1;
          r.out_byte   = b;
          total_out    = total_out + 1'b1;
          size_left    = size_left - 1'b1;
          if (size_left == '0) parse_ph = P_DATA_CR;
        end
        P_DATA_CR: begin
          if (b == CHAR_CR) parse_ph = P_DATA_LF;
          else body_status = ST_NOCRLF;
        end
        P_DATA_LF: begin
          if (b == CHAR_LF) begin
            parse_ph   = P_LINE_START;
            size_left  = '0;
            digit_seen = 1'b0;
          end else begin
            body_status = ST_NOCRLF;
          end
        end
        default: body_status = ST_BADLINE;
      endcase
      // end of input before the zero chunk: the code depends on where we stopped
      if (last && body_status == ST_RUN) begin
        case (parse_ph)
          P_LINE_START:         body_status = ST_EARLY;
          P_DATA:               body_status = ST_SHORT;
          P_DATA_CR, P_DATA_LF: body_status = ST_NOCRLF;
          default:              body_status = ST_BADLINE;
        endcase
      end
    end
    r.status      = body_status;
    r.body_length = total_out;
    return r;
  endfunction

  function automatic void plan_byte(logic [7:0] b, logic last);
    plan.push_back({1'b0, {LEN_W{1'b0}}, b, last, 1'b0, {$bits(result_t){1'b0}}});
  endfunction

  function automatic void plan_check(logic [7:0] b, logic last, result_t want);
    plan.push_back({1'b0, {LEN_W{1'b0}}, b, last, 1'b1, want});
  endfunction

  function automatic void plan_cfg(logic [LEN_W-1:0] v);
    plan.push_back({1'b1, v, {$bits(item_t){1'b0}}, 1'b0, {$bits(result_t){1'b0}}});
  endfunction

  // Predict, queue the expectation, then present the byte after a random gap.
  // Entered just after a rising edge; valid is only touched at falling edges.
  task automatic put_byte(logic [7:0] b, logic last, logic typed, result_t want);
    result_t pred;
    int      gap;
    if (body_status == ST_RUN) live_items++;
    pred = decode_step(b, last);
    pending_results.push_back(typed ? want : pred);
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put(logic [7:0] b, logic last);
    put_byte(b, last, 1'b0, '0);
  endtask

  // Register writes only with the decoder drained: every byte gives exactly one
  // result, so an empty expectation queue means nothing is in flight.
  task automatic set_max_body(logic [LEN_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    max_body_lim = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Size in hex, sometimes with leading zeros.
  task automatic send_size(int n);
    int nd;
    nd = 1;
    while ((n >> (4 * nd)) != 0) nd++;
    if ($urandom_range(0, 3) == 0) nd += $urandom_range(1, 2);
    for (int i = nd - 1; i >= 0; i--) put(ascii_hex(4'((n >> (4 * i)) & 15)), 1'b0);
  endtask

  // ';' and a few skipped bytes; LF may show up, CR would end it
  task automatic put_ext();
    put(CHAR_SEMI, 1'b0);
    repeat ($urandom_range(0, 4)) put(any_byte_but(CHAR_CR), 1'b0);
  endtask

  // Size line and data of one chunk, without the closing CRLF.
  task automatic send_head_data(int n);
    send_size(n);
    if ($urandom_range(0, 3) == 0) put_ext();
    put(CHAR_CR, 1'b0);
    put(CHAR_LF, 1'b0);
    repeat (n) put(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Result side: after each result, hold ready low for a drawn number of cycles.
  initial begin
    int seen_before;
    int stall;
    seen_before = 0;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen != seen_before) begin
        seen_before = results_seen;
        if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
        stall = calm_out ? 0 : $urandom_range(0, 14);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= !rst;
      end
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.data_valid !== oldest.data_valid) begin
          $error("data_valid: expected %0d, got %0d", oldest.data_valid, out_data.data_valid);
          mismatch_count++;
        end
        if (out_data.out_byte !== oldest.out_byte) begin
          $error("out_byte: expected %0h, got %0h", oldest.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (out_data.status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.body_length !== oldest.body_length) begin
          $error("body_length: expected %0d, got %0d", oldest.body_length,
                 out_data.body_length);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    int k;
    int kind;
    logic tight;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    // Directed table. Smallest limit first: only a one-byte chunk fits.
    plan_cfg(LEN_W'(1));
    plan_check("1", 1'b0, {1'b0, 8'h00, ST_RUN, 21'd0});
    plan_byte(CHAR_CR, 1'b0);
    plan_byte(CHAR_LF, 1'b0);
    plan_check(8'hFF, 1'b0, {1'b1, 8'hFF, ST_RUN, 21'd1});
    plan_byte(CHAR_CR, 1'b0);
    plan_check(CHAR_LF, 1'b0, {1'b0, 8'h00, ST_RUN, 21'd1});
    // back to the full 1 MiB limit
    plan_cfg(MAX_BODY_RESET);
    // extension holding a bare LF, which is skipped
    plan_byte("2", 1'b0);
    plan_byte(CHAR_SEMI, 1'b0);
    plan_byte(CHAR_LF, 1'b0);
    plan_byte(CHAR_CR, 1'b0);
    plan_byte(CHAR_LF, 1'b0);
    plan_check(8'h00, 1'b0, {1'b1, 8'h00, ST_RUN, 21'd2});
    plan_check(8'h80, 1'b0, {1'b1, 8'h80, ST_RUN, 21'd3});
    plan_byte(CHAR_CR, 1'b0);
    plan_byte(CHAR_LF, 1'b0);
    // leading zero in the size
    plan_byte("0", 1'b0);
    plan_byte("1", 1'b0);
    plan_byte(CHAR_CR, 1'b0);
    plan_byte(CHAR_LF, 1'b0);
    plan_check(8'h5A, 1'b0, {1'b1, 8'h5A, ST_RUN, 21'd4});
    plan_byte(CHAR_CR, 1'b0);
    plan_byte(CHAR_LF, 1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) set_max_body(plan[i].cfg_val);
      else put_byte(plan[i].stim.in_byte, plan[i].stim.last_byte, plan[i].typed, plan[i].want);
    end

    // Reset comes only once and every error is sticky, so the run is one long
    // body: well-formed chunks with random content, sizes, spelling and
    // extensions; now and then the limit is pulled down to exactly fit (or
    // nearly fit) the next chunk and then relaxed again.
    while (live_items < LIVE_TARGET) begin
      n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      tight = ($urandom_range(0, 9) == 0);
      if (tight)
        set_max_body(LEN_W'(int'(total_out) + n + ($urandom_range(0, 1) ? 0 :
                                                     $urandom_range(1, 3))));
      send_head_data(n);
      put(CHAR_CR, 1'b0);
      put(CHAR_LF, 1'b0);
      if (tight)
        set_max_body(LEN_W'($urandom_range(int'(total_out) + 2048, int'(MAX_BODY_RESET))));
    end

    // How the body ends: clean zero chunk or one of the broken endings.
    kind = $urandom_range(0, 13);
    case (kind)
      0: begin  // zero chunk, maybe with extension, maybe flagged last
        put("0", 1'b0);
        if ($urandom_range(0, 1)) put_ext();
        put(CHAR_CR, 1'b0);
        put(CHAR_LF, 1'($urandom_range(0, 1)));
      end
      1: begin  // junk where a hex digit belongs
        k = $urandom_range(0, 255);
        while (hex_digit(8'(k)) >= 0 || 8'(k) == CHAR_CR || 8'(k) == CHAR_LF ||
               8'(k) == CHAR_SEMI)
          k = $urandom_range(0, 255);
        put(8'(k), 1'($urandom_range(0, 1)));
      end
      2: begin  // size grows past the limit
        put(ascii_hex(4'($urandom_range(1, 15))), 1'b0);
        k = 0;
        while (body_status == ST_RUN && k < 10) begin
          put(ascii_hex(4'($urandom_range(0, 15))), 1'b0);
          k++;
        end
      end
      3: begin  // bare LF in the size line
        repeat ($urandom_range(0, 2)) put("1", 1'b0);
        put(CHAR_LF, 1'b0);
      end
      4: put(CHAR_CR, 1'b0);  // empty size line
      5: begin  // extension with no size in front
        put_ext();
        put(CHAR_CR, 1'b0);
      end
      6: begin  // CR of the size line not followed by LF
        put("3", 1'b0);
        put(CHAR_CR, 1'b0);
        put(any_byte_but(CHAR_LF), 1'b0);
      end
      7: put("5", 1'b1);  // input stops inside a size line
      8: begin  // input stops inside chunk data
        n = $urandom_range(2, 9);
        send_size(n);
        put(CHAR_CR, 1'b0);
        put(CHAR_LF, 1'b0);
        k = $urandom_range(1, n - 1);
        repeat (k - 1) put(8'($urandom_range(0, 255)), 1'b0);
        put(8'($urandom_range(0, 255)), 1'b1);
      end
      9: begin  // running total would pass the limit by one byte
        n = $urandom_range(1, 9);
        set_max_body(LEN_W'(int'(total_out) + n - 1));
        send_size(n);
        put(CHAR_CR, 1'b0);
        put(CHAR_LF, 1'b0);
      end
      10: begin  // data not followed by CR
        send_head_data($urandom_range(1, 6));
        put(any_byte_but(CHAR_CR), 1'b0);
      end
      11: begin  // CR after data not followed by LF
        send_head_data($urandom_range(1, 6));
        put(CHAR_CR, 1'b0);
        put(any_byte_but(CHAR_LF), 1'b0);
      end
      12: begin  // input stops between the CR and LF after data
        send_head_data($urandom_range(1, 6));
        put(CHAR_CR, 1'b1);
      end
      default: begin  // input stops cleanly after a chunk, before the zero chunk
        send_head_data($urandom_range(1, 6));
        put(CHAR_CR, 1'b0);
        put(CHAR_LF, 1'b1);
      end
    endcase

    // Once finished or failed the decoder only repeats its status.
    repeat ($urandom_range(4, 12)) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // keep the clock running so a stray extra result would still be caught
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/chd_pkg.sv
rtl/chd_in_reg.sv
rtl/chd_engine.sv
rtl/http_chunked_body_decoder_top.sv
sim/tb_http_chunked_body_decoder_top.sv
